>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion whose consequent is checked in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/u2u_pkg.sv
`default_nettype none

package u2u_pkg;

  // Default capacity of one frame in UTF-16 code units.
  localparam int unsigned MAX_UNITS_DEFAULT = 128;

  // Item actions.
  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_TEXT  = 2'd1,
    ACT_END   = 2'd2
  } action_e;

  // Kinds of command handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_HEADER  = 2'd0,
    CMD_UNIT    = 2'd1,
    CMD_TRAILER = 2'd2
  } cmd_kind_e;

  // One queued command: ids for a header, a code unit in the low half.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] data;
  } cmd_t;

  // Head of the command queue as the back sees it.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Frame header and trailer bytes.
  localparam logic [7:0] HDR_B0 = 8'hAA;
  localparam logic [7:0] HDR_B1 = 8'hB1;
  localparam logic [7:0] HDR_B2 = 8'h10;
  localparam logic [7:0] TRL_B0 = 8'hCC;
  localparam logic [7:0] TRL_B1 = 8'h33;
  localparam logic [7:0] TRL_B2 = 8'hC3;
  localparam logic [7:0] TRL_B3 = 8'h3C;

  // Index of the last byte for each command kind.
  localparam logic [2:0] HDR_LAST_IDX = 3'd6;
  localparam logic [2:0] UNIT_LAST_IDX = 3'd1;
  localparam logic [2:0] TRL_LAST_IDX = 3'd3;

endpackage

`default_nettype wire

>>> sv/u2u_front.sv
`default_nettype none

module u2u_front import u2u_pkg::*; #(
  parameter int unsigned MAX_UNITS = MAX_UNITS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pure_mode_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] screen_number_i,
  input  wire logic [15:0] control_number_i,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output cmd_t             push_cmd_o
);

  localparam int unsigned UnitW = $clog2(MAX_UNITS + 1);
  localparam logic [UnitW-1:0] UnitMax = UnitW'(MAX_UNITS);

  logic [1:0]       pend_q, pend_d;
  logic [15:0]      partial_q, partial_d;
  logic [UnitW-1:0] units_q, units_d;
  logic             accept;
  logic             emit;
  logic             unit_req;
  logic [15:0]      unit_code;
  cmd_t             cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decoder state and command selection for the item at the port.
  always_comb begin
    pend_d    = pend_q;
    partial_d = partial_q;
    units_d   = units_q;
    emit      = 1'b0;
    unit_req  = 1'b0;
    unit_code = 16'h0000;
    cmd.kind  = CMD_UNIT;
    cmd.data  = 32'h0;
    unique case (action_i)
      ACT_BEGIN: begin
        pend_d    = 2'd0;
        partial_d = 16'h0000;
        units_d   = '0;
        emit      = 1'b1;
        cmd.kind  = CMD_HEADER;
        cmd.data  = {screen_number_i, control_number_i};
      end
      ACT_TEXT: begin
        if (pend_q == 2'd2) begin
          partial_d = partial_q | {4'h0, text_byte_i[5:0], 6'h00};
          pend_d    = 2'd1;
        end else if (pend_q == 2'd1) begin
          unit_code = partial_q | {10'h000, text_byte_i[5:0]};
          unit_req  = 1'b1;
          pend_d    = 2'd0;
          partial_d = 16'h0000;
        end else if (!text_byte_i[7]) begin
          unit_code = {8'h00, text_byte_i};
          unit_req  = 1'b1;
        end else if (text_byte_i[7:5] == 3'b110) begin
          partial_d = {5'h00, text_byte_i[4:0], 6'h00};
          pend_d    = 2'd1;
        end else if (text_byte_i[7:4] == 4'b1110) begin
          partial_d = {text_byte_i[3:0], 12'h000};
          pend_d    = 2'd2;
        end
        // A finished character counts and goes out only while there is room.
        if (unit_req && (units_q < UnitMax)) begin
          units_d  = units_q + UnitW'(1);
          emit     = 1'b1;
          cmd.kind = CMD_UNIT;
          cmd.data = {16'h0000, unit_code};
        end
      end
      ACT_END: begin
        pend_d    = 2'd0;
        partial_d = 16'h0000;
        units_d   = '0;
        emit      = 1'b1;
        cmd.kind  = CMD_TRAILER;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // State changes in pure mode too; only the push is held back.
  assign push_o     = accept && emit && !pure_mode_i;
  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 2'd0;
      partial_q <= 16'h0000;
      units_q   <= '0;
    end else if (accept) begin
      pend_q    <= pend_d;
      partial_q <= partial_d;
      units_q   <= units_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/u2u_queue.sv
`default_nettype none

module u2u_queue import u2u_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  input  wire logic pop_i,
  output logic      full_o,
  output q_head_t   head_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o       = (count_q == 2'd2);
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/u2u_back.sv
`default_nettype none

module u2u_back import u2u_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire q_head_t    head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            frame_last_o
);

  logic [2:0] idx_q;
  logic [2:0] last_idx;
  logic       is_last;
  logic       xfer;

  assign out_valid_o = head_i.valid;
  assign xfer        = out_valid_o && out_ready_i;

  // Byte selection for the current position within the head command.
  always_comb begin
    out_byte_o = 8'h00;
    last_idx   = UNIT_LAST_IDX;
    unique case (head_i.cmd.kind)
      CMD_HEADER: begin
        last_idx = HDR_LAST_IDX;
        case (idx_q)
          3'd0:    out_byte_o = HDR_B0;
          3'd1:    out_byte_o = HDR_B1;
          3'd2:    out_byte_o = HDR_B2;
          3'd3:    out_byte_o = head_i.cmd.data[31:24];
          3'd4:    out_byte_o = head_i.cmd.data[23:16];
          3'd5:    out_byte_o = head_i.cmd.data[15:8];
          default: out_byte_o = head_i.cmd.data[7:0];
        endcase
      end
      CMD_UNIT: begin
        last_idx   = UNIT_LAST_IDX;
        out_byte_o = idx_q[0] ? head_i.cmd.data[7:0] : head_i.cmd.data[15:8];
      end
      CMD_TRAILER: begin
        last_idx = TRL_LAST_IDX;
        case (idx_q[1:0])
          2'd0:    out_byte_o = TRL_B0;
          2'd1:    out_byte_o = TRL_B1;
          2'd2:    out_byte_o = TRL_B2;
          default: out_byte_o = TRL_B3;
        endcase
      end
      default: begin
        last_idx   = UNIT_LAST_IDX;
        out_byte_o = 8'h00;
      end
    endcase
  end

  assign is_last      = (idx_q == last_idx);
  assign frame_last_o = is_last && (head_i.cmd.kind == CMD_TRAILER);
  assign pop_o        = xfer && is_last;

  // Byte position within the head command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (xfer) begin
      idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

endmodule

`default_nettype wire

>>> sv/utf8_to_utf16be_text_framer.sv
// Text-update frame builder. Items enter on the in_* channel: a begin item
// emits AA B1 10 and the screen and control ids high byte first, each text
// item feeds one UTF-8 byte to a decoder that emits each finished character
// as a UTF-16BE code unit, and an end item emits CC 33 C3 3C with
// frame_last_o set on the final byte. At most MAX_UNITS code units go out
// per frame; the pure mode register silences the output of items taken while
// it is set. The front accepts one item per cycle while its two-entry command
// queue has room, and the back sends one byte per cycle while out_ready_i is
// high. An item yields 2 bytes for a character, 7 for a begin, 4 for an end,
// none for a lead or dropped byte. Plain ASCII text is limited by the
// one-byte-wide output serializer, since each character becomes two bytes.
`default_nettype none

module utf8_to_utf16be_text_framer import u2u_pkg::*; #(
  parameter int unsigned MAX_UNITS = MAX_UNITS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_pure_mode_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] screen_number_i,
  input  wire logic [15:0] control_number_i,
  input  wire logic [7:0]  text_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             frame_last_o
);

  logic    pure_mode_q;
  logic    q_full;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  q_head_t head;

  // Configuration register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pure_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pure_mode_q <= cfg_pure_mode_i;
    end
  end

  // Front: accepts items, decodes UTF-8 and queues commands.
  u2u_front #(
    .MAX_UNITS(MAX_UNITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .pure_mode_i      (pure_mode_q),
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .screen_number_i,
    .control_number_i,
    .text_byte_i,
    .q_full_i         (q_full),
    .push_o           (push),
    .push_cmd_o       (push_cmd)
  );

  // Command queue between front and back.
  u2u_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .full_o     (q_full),
    .head_o     (head)
  );

  // Back: serializes each command into frame bytes.
  u2u_back u_back (
    .clk_i,
    .rst_ni,
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .frame_last_o
  );

endmodule

`default_nettype wire

>>> sv/u2u_checker.sv
`default_nettype none
`include "assert_macros.svh"

module u2u_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       frame_last_o
);

  logic       last_shown;
  logic       out_stalled;
  logic [9:0] out_word;

  assign last_shown  = out_valid_o && frame_last_o;
  assign out_stalled = out_valid_o && !out_ready_i;
  assign out_word    = {out_valid_o, frame_last_o, out_byte_o};

  // The frame end flag only ever marks the final trailer byte.
  `ASSERT_AT(a_last_3c, clk_i, rst_ni, last_shown |-> (out_byte_o == 8'h3C), "bad last byte")

  // With nothing waiting at the output the block must take items.
  `ASSERT_AT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "stall while empty")

  // A stalled output transaction holds its valid, byte and flag.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stalled, $stable(out_word), "stalled output changed")

endmodule

bind utf8_to_utf16be_text_framer u2u_checker u_chk (.*);

`default_nettype wire

>>> tb/tb_utf8_to_utf16be_text_framer.sv
`timescale 1ns / 1ps

module tb_utf8_to_utf16be_text_framer;
  import u2u_pkg::*;

  localparam int unsigned UNIT_LIMIT = MAX_UNITS_DEFAULT;
  localparam int CLK_HALF = 6;
  localparam int SETTLE_CYCLES = 32;
  localparam int WATCHDOG_CYCLES = 300_000;

  // Expected frame bytes, the decoder state and the unit count of the open frame.
  class frame_predictor;
    typedef struct packed {
      logic [7:0] value;
      logic       last;
    } frame_byte_t;

    frame_byte_t expected_bytes[$];
    bit          pure_mode;
    logic [1:0]  conts_left;
    logic [15:0] code_acc;
    int unsigned unit_count;
    int unsigned error_count;

    function void restart_frame();
      conts_left = 2'd0;
      code_acc = 16'h0000;
      unit_count = 0;
    endfunction

    function void set_pure(bit v);
      pure_mode = v;
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction

    // While pure mode is on, the state moves but no byte goes out.
    function void push_byte(logic [7:0] v, logic last);
      frame_byte_t fb;
      if (pure_mode) return;
      fb.value = v;
      fb.last = last;
      expected_bytes.push_back(fb);
    endfunction

    // Characters past the frame capacity are decoded but dropped.
    function void push_unit(logic [15:0] code);
      if (unit_count >= UNIT_LIMIT) return;
      unit_count++;
      push_byte(code[15:8], 1'b0);
      push_byte(code[7:0], 1'b0);
    endfunction

    // Work out the bytes that one accepted transaction should produce.
    function void accept_item(action_e act, logic [15:0] scr, logic [15:0] ctl,
                              logic [7:0] b);
      case (act)
        ACT_BEGIN: begin
          restart_frame();
          push_byte(HDR_B0, 1'b0);
          push_byte(HDR_B1, 1'b0);
          push_byte(HDR_B2, 1'b0);
          push_byte(scr[15:8], 1'b0);
          push_byte(scr[7:0], 1'b0);
          push_byte(ctl[15:8], 1'b0);
          push_byte(ctl[7:0], 1'b0);
        end
        ACT_TEXT: begin
          if (conts_left == 2'd2) begin
            code_acc = code_acc | {4'b0000, b[5:0], 6'b000000};
            conts_left = 2'd1;
          end else if (conts_left == 2'd1) begin
            push_unit(code_acc | {10'b0, b[5:0]});
            conts_left = 2'd0;
            code_acc = 16'h0000;
          end else if (b < 8'h80) begin
            push_unit({8'h00, b});
          end else if (b[7:5] == 3'b110) begin
            code_acc = {5'b00000, b[4:0], 6'b000000};
            conts_left = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            code_acc = {b[3:0], 12'h000};
            conts_left = 2'd2;
          end
          // Stray continuations and four-byte leads fall through silently.
        end
        ACT_END: begin
          restart_frame();
          push_byte(TRL_B0, 1'b0);
          push_byte(TRL_B1, 1'b0);
          push_byte(TRL_B2, 1'b0);
          push_byte(TRL_B3, 1'b1);
        end
        default: ;
      endcase
    endfunction

    // Compare one output transaction with the oldest expected byte.
    function void check_byte(logic [7:0] value, logic last);
      frame_byte_t fb;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: nothing expected, got %02h (frame_last %0b)", value, last);
        error_count++;
        return;
      end
      fb = expected_bytes.pop_front();
      if (value !== fb.value) begin
        $error("out_byte: expected %02h, got %02h", fb.value, value);
        error_count++;
      end
      if (last !== fb.last) begin
        $error("frame_last: expected %0b, got %0b", fb.last, last);
        error_count++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_pure_mode_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = ACT_BEGIN;
  logic [15:0] screen_number_i = 16'h0000;
  logic [15:0] control_number_i = 16'h0000;
  logic [7:0]  text_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        frame_last_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  frame_predictor model = new;

  utf8_to_utf16be_text_framer #(
    .MAX_UNITS(UNIT_LIMIT)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_pure_mode_i(cfg_pure_mode_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .action_i(action_i),
    .screen_number_i(screen_number_i),
    .control_number_i(control_number_i),
    .text_byte_i(text_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o(out_byte_o),
    .frame_last_o(frame_last_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Output side: check each transaction and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      model.check_byte(out_byte_o, frame_last_o);
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one item and hold it until the block takes it. Valid is left high
  // so that a following item can go out back to back.
  task automatic send_item(action_e act, logic [15:0] scr, logic [15:0] ctl,
                           logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    screen_number_i <= scr;
    control_number_i <= ctl;
    text_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model.accept_item(act, scr, ctl, b);
  endtask

  task automatic send_begin(logic [15:0] scr, logic [15:0] ctl);
    send_item(ACT_BEGIN, scr, ctl, 8'($urandom));
  endtask

  task automatic send_text(logic [7:0] b);
    send_item(ACT_TEXT, 16'($urandom), 16'($urandom), b);
  endtask

  task automatic send_end();
    send_item(ACT_END, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic write_pure(bit v);
    cfg_pure_mode_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model.set_pure(v);
    cfg_valid_i <= 1'b0;
  endtask

  // Let every expected byte arrive, then give dropped items time to retire.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (model.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly whole characters inside frames, with stray and broken bytes mixed in.
  task automatic send_random(int n);
    int sent;
    int unsigned pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_begin(16'($urandom), 16'($urandom));
        sent += 1;
      end else if (pick < 22) begin
        send_end();
        sent += 1;
      end else if (pick < 50) begin
        send_text(8'($urandom_range(8'h7F)));
        sent += 1;
      end else if (pick < 65) begin
        send_text(8'h C0 | 8'($urandom_range(31)));
        send_text(8'h80 | 8'($urandom_range(63)));
        sent += 2;
      end else if (pick < 80) begin
        send_text(8'hE0 | 8'($urandom_range(15)));
        send_text(8'h80 | 8'($urandom_range(63)));
        send_text(8'h80 | 8'($urandom_range(63)));
        sent += 3;
      end else if (pick < 87) begin
        send_text(8'h80 | 8'($urandom_range(63)));
        sent += 1;
      end else if (pick < 92) begin
        send_text(8'hF0 | 8'($urandom_range(15)));
        sent += 1;
      end else begin
        send_text(8'($urandom));
        sent += 1;
      end
    end
  endtask

  initial begin
    model.restart_frame();
    model.set_pure(1'b0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_pure(1'b0);

    // Directed: orphan text and end, id extremes, decoder corner cases.
    send_text(8'h41);
    send_end();
    send_begin(16'hFFFF, 16'h0000);
    send_text(8'h00);
    send_text(8'h7F);
    send_text(8'h80);
    send_text(8'hF0);
    send_text(8'hFF);
    send_text(8'hC2);
    send_text(8'hA9);
    send_text(8'hE2);
    send_text(8'h82);
    send_text(8'hAC);
    send_text(8'hEF);
    send_text(8'hBF);
    send_text(8'hBF);
    // A lead followed by a plain byte still completes the character.
    send_text(8'hC3);
    send_text(8'h41);
    // A begin in the middle of a sequence restarts the decoder.
    send_text(8'hE4);
    send_begin(16'h0000, 16'hFFFF);
    // An end drops the unfinished sequence.
    send_text(8'hE4);
    send_text(8'h80);
    send_end();

    // One frame that runs past its capacity.
    send_begin(16'($urandom), 16'($urandom));
    repeat (UNIT_LIMIT + 6) begin
      if ($urandom_range(9) == 0) begin
        send_text(8'hC0 | 8'($urandom_range(31)));
        send_text(8'h80 | 8'($urandom_range(63)));
      end else begin
        send_text(8'($urandom_range(8'h7F)));
      end
    end
    send_end();

    send_random(20);
    wait_idle();

    // Output suppressed while the decoder keeps running.
    write_pure(1'b1);
    send_idle_pct = 51;
    send_random(30);
    wait_idle();
    write_pure(1'b0);

    send_random(70);
    wait_idle();

    send_idle_pct = 0;
    recv_stall_pct = 51;
    send_random(70);
    wait_idle();

    send_idle_pct = 22;
    recv_stall_pct = 22;
    send_random(70);
    wait_idle();

    if (model.error_count == 0 && model.outstanding() == 0) begin
      $display("utf8_to_utf16be_text_framer: match");
    end else begin
      $display("utf8_to_utf16be_text_framer: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(WATCHDOG_CYCLES * 2 * CLK_HALF);
    $display("utf8_to_utf16be_text_framer: mismatch");
    $finish;
  end

endmodule
